>>> sv/ldrlux_pkg.sv
// Shared constants, types and the constant resistance/lux table of the LDR linearizer.
package ldrlux_pkg;

    localparam int TAB_ENTRIES = 37;
    localparam int IDX_W       = 6;
    localparam int REF_W       = 12;
    localparam int SER_W       = 20;
    localparam int RES_W       = 24;
    localparam int TRES_W      = 17;
    localparam int LUX_W       = 14;
    localparam int RATIO_W     = 18;
    localparam int LUXM_W      = 24;
    localparam int LUX100_W    = 20;

    localparam int DIV_NUM_W   = 40;
    localparam int DIV_DEN_W   = 17;
    localparam int DIV_ITERS   = DIV_NUM_W / 2;
    localparam int DIV_CNT_W   = 5;

    localparam logic [RES_W-1:0]     RES_MAX     = 24'hFFFFFF;
    localparam logic [DIV_NUM_W-1:0] QUOT_LIMIT  = 40'd163840;
    localparam logic [RATIO_W-1:0]   RATIO_MIN   = 18'h20000;
    localparam logic [REF_W-1:0]     REF_RESET   = 12'd3300;
    localparam logic [SER_W-1:0]     SER_RESET   = 20'd10000;

    // Register indexes, decoded from address bit 2.
    localparam logic REG_REFERENCE = 1'b0;
    localparam logic REG_SERIES    = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [TRES_W-1:0] tab_res_f(input logic [IDX_W-1:0] idx);
        logic [TRES_W-1:0] res;
        case (idx)
            6'd0:  res = 17'd100000;
            6'd1:  res = 17'd70000;
            6'd2:  res = 17'd50000;
            6'd3:  res = 17'd38000;
            6'd4:  res = 17'd35000;
            6'd5:  res = 17'd33000;
            6'd6:  res = 17'd31000;
            6'd7:  res = 17'd30000;
            6'd8:  res = 17'd29000;
            6'd9:  res = 17'd27000;
            6'd10: res = 17'd19000;
            6'd11: res = 17'd15000;
            6'd12: res = 17'd13000;
            6'd13: res = 17'd11000;
            6'd14: res = 17'd9000;
            6'd15: res = 17'd8500;
            6'd16: res = 17'd8000;
            6'd17: res = 17'd7500;
            6'd18: res = 17'd7000;
            6'd19: res = 17'd5000;
            6'd20: res = 17'd4000;
            6'd21: res = 17'd3300;
            6'd22: res = 17'd3000;
            6'd23: res = 17'd2700;
            6'd24: res = 17'd2500;
            6'd25: res = 17'd2300;
            6'd26: res = 17'd2100;
            6'd27: res = 17'd1900;
            6'd28: res = 17'd1500;
            6'd29: res = 17'd1100;
            6'd30: res = 17'd1000;
            6'd31: res = 17'd950;
            6'd32: res = 17'd800;
            6'd33: res = 17'd700;
            6'd34: res = 17'd650;
            6'd35: res = 17'd500;
            6'd36: res = 17'd480;
            default: res = 17'd1;
        endcase
        return res;
    endfunction

    function automatic logic [LUX_W-1:0] tab_lux_f(input logic [IDX_W-1:0] idx);
        logic [LUX_W-1:0] lux;
        case (idx)
            6'd0:  lux = 14'd1;
            6'd1:  lux = 14'd2;
            6'd2:  lux = 14'd3;
            6'd3:  lux = 14'd4;
            6'd4:  lux = 14'd5;
            6'd5:  lux = 14'd6;
            6'd6:  lux = 14'd7;
            6'd7:  lux = 14'd8;
            6'd8:  lux = 14'd9;
            6'd9:  lux = 14'd10;
            6'd10: lux = 14'd20;
            6'd11: lux = 14'd30;
            6'd12: lux = 14'd40;
            6'd13: lux = 14'd50;
            6'd14: lux = 14'd60;
            6'd15: lux = 14'd70;
            6'd16: lux = 14'd80;
            6'd17: lux = 14'd90;
            6'd18: lux = 14'd100;
            6'd19: lux = 14'd200;
            6'd20: lux = 14'd300;
            6'd21: lux = 14'd400;
            6'd22: lux = 14'd500;
            6'd23: lux = 14'd600;
            6'd24: lux = 14'd700;
            6'd25: lux = 14'd800;
            6'd26: lux = 14'd900;
            6'd27: lux = 14'd1000;
            6'd28: lux = 14'd2000;
            6'd29: lux = 14'd3000;
            6'd30: lux = 14'd4000;
            6'd31: lux = 14'd5000;
            6'd32: lux = 14'd6000;
            6'd33: lux = 14'd7000;
            6'd34: lux = 14'd8000;
            6'd35: lux = 14'd9000;
            6'd36: lux = 14'd10000;
            default: lux = 14'd0;
        endcase
        return lux;
    endfunction

endpackage

>>> sv/ldrlux_div.sv
// Radix-4 restoring divider, two quotient bits per cycle, shared by both divisions.
module ldrlux_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [ldrlux_pkg::DIV_NUM_W-1:0]    dividend,
    input  logic [ldrlux_pkg::DIV_DEN_W-1:0]    divisor,
    output ldrlux_pkg::div_stat_t               stat,
    output logic [ldrlux_pkg::DIV_NUM_W-1:0]    quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [ldrlux_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [ldrlux_pkg::DIV_DEN_W-1:0]    rem_reg;
    logic [ldrlux_pkg::DIV_DEN_W-1:0]    den_reg;
    logic [ldrlux_pkg::DIV_NUM_W-1:0]    quot_reg;

    logic [ldrlux_pkg::DIV_DEN_W:0]      trial1;
    logic [ldrlux_pkg::DIV_DEN_W:0]      trial2;
    logic [ldrlux_pkg::DIV_DEN_W:0]      den_ext;
    logic                                ge1;
    logic                                ge2;
    logic [ldrlux_pkg::DIV_DEN_W-1:0]    rem1;
    logic [ldrlux_pkg::DIV_DEN_W-1:0]    rem_next;
    logic [ldrlux_pkg::DIV_NUM_W-1:0]    quot1;
    logic [ldrlux_pkg::DIV_NUM_W-1:0]    quot_next;
    logic [ldrlux_pkg::DIV_DEN_W:0]      diff1;
    logic [ldrlux_pkg::DIV_DEN_W:0]      diff2;

    always_comb begin
        den_ext  = {1'b0, den_reg};
        trial1   = {rem_reg, quot_reg[ldrlux_pkg::DIV_NUM_W-1]};
        ge1      = trial1 >= den_ext;
        diff1    = trial1 - den_ext;
        rem1     = ge1 ? diff1[ldrlux_pkg::DIV_DEN_W-1:0]
                       : trial1[ldrlux_pkg::DIV_DEN_W-1:0];
        quot1    = {quot_reg[ldrlux_pkg::DIV_NUM_W-2:0], ge1};
        trial2   = {rem1, quot1[ldrlux_pkg::DIV_NUM_W-1]};
        ge2      = trial2 >= den_ext;
        diff2    = trial2 - den_ext;
        rem_next = ge2 ? diff2[ldrlux_pkg::DIV_DEN_W-1:0]
                       : trial2[ldrlux_pkg::DIV_DEN_W-1:0];
        quot_next = {quot1[ldrlux_pkg::DIV_NUM_W-2:0], ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ldrlux_pkg::DIV_CNT_W'(ldrlux_pkg::DIV_ITERS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            den_reg  <= divisor;
            quot_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

>>> sv/ldr_lux_table_linearizer_core.sv
// Top level of the LDR linearizer: control sequencer, table ROM, ratio and lux arithmetic.
//
// A voltage sample (s_sample_mv) is taken on the s_ valid/ready channel while the
// block is idle. Below the reference, the sensor resistance is found with a shared
// radix-4 divider; at or above it, the resistance saturates to the maximum. The
// table ROM is then read one entry per cycle, after two start-up reads, until the
// nearest entry is found. The divider then runs a second time, after a load step,
// for the ratio r / table resistance; a multiply step forms the lux value and the
// output register is then loaded. One item is worked on at a time.
// The result sits in an output register on the m_ channel; while the receiver
// stalls, the next sample is still accepted and processed, and the block then
// waits with its finished result until the output register is free.
// Both registers are written over the APB port (reference at 0x0, series
// resistor at 0x4) and should only be changed while no request is in flight.
// Synchronous reset returns the block to idle, drops any pending result and
// restores the reference to 3300 mV and the series resistor to 10000 ohms.
module ldr_lux_table_linearizer_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [2:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [ldrlux_pkg::REF_W-1:0]           s_sample_mv,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [ldrlux_pkg::RES_W-1:0]           m_resistance_ohms,
    output logic [ldrlux_pkg::IDX_W-1:0]           m_entry_index,
    output logic [ldrlux_pkg::LUX_W-1:0]           m_table_lux_deci,
    output logic signed [ldrlux_pkg::RATIO_W-1:0]  m_ratio_q14,
    output logic signed [ldrlux_pkg::LUXM_W-1:0]   m_lux_milli,
    output logic                                   m_saturated
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV1   = 4'd1;
    localparam logic [3:0] S_ROM0   = 4'd2;
    localparam logic [3:0] S_ROM1   = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_START2 = 4'd5;
    localparam logic [3:0] S_DIV2   = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam logic [ldrlux_pkg::IDX_W-1:0] LAST_IDX =
        ldrlux_pkg::IDX_W'(ldrlux_pkg::TAB_ENTRIES - 1);
    localparam logic [ldrlux_pkg::IDX_W-1:0] LAST_CMP_IDX =
        ldrlux_pkg::IDX_W'(ldrlux_pkg::TAB_ENTRIES - 2);

    logic [3:0]                              state_reg;
    logic [3:0]                              state_next;
    logic [ldrlux_pkg::REF_W-1:0]            ref_reg;
    logic [ldrlux_pkg::SER_W-1:0]            ser_reg;
    logic [ldrlux_pkg::IDX_W-1:0]            addr_reg;
    logic                                    m_valid_reg;

    logic [ldrlux_pkg::TRES_W-1:0]           rom_res_reg;
    logic [ldrlux_pkg::LUX_W-1:0]            rom_lux_reg;
    logic [ldrlux_pkg::TRES_W-1:0]           prev_res_reg;
    logic [ldrlux_pkg::LUX_W-1:0]            prev_lux_reg;
    logic [ldrlux_pkg::IDX_W-1:0]            prev_idx_reg;
    logic [ldrlux_pkg::TRES_W-1:0]           sel_res_reg;
    logic [ldrlux_pkg::LUX_W-1:0]            sel_lux_reg;
    logic [ldrlux_pkg::IDX_W-1:0]            sel_idx_reg;
    logic [ldrlux_pkg::RES_W-1:0]            r_reg;
    logic                                    sat_reg;
    logic [ldrlux_pkg::RATIO_W-1:0]          ratio_reg;
    logic [ldrlux_pkg::LUX100_W-1:0]         lux100_reg;
    logic signed [38:0]                      prod_reg;

    logic [ldrlux_pkg::RES_W-1:0]            m_res_reg;
    logic [ldrlux_pkg::IDX_W-1:0]            m_idx_reg;
    logic [ldrlux_pkg::LUX_W-1:0]            m_lux_reg;
    logic [ldrlux_pkg::RATIO_W-1:0]          m_ratio_reg;
    logic [ldrlux_pkg::LUXM_W-1:0]           m_luxm_reg;
    logic                                    m_sat_reg;

    logic                                    cfg_wr;
    logic                                    accept;
    logic                                    sample_ge;
    logic [ldrlux_pkg::REF_W-1:0]            ref_diff;
    logic [31:0]                             volt_prod;
    logic                                    div_start;
    logic [ldrlux_pkg::DIV_NUM_W-1:0]        div_num;
    logic [ldrlux_pkg::DIV_DEN_W-1:0]        div_den;
    ldrlux_pkg::div_stat_t                   div_stat;
    logic [ldrlux_pkg::DIV_NUM_W-1:0]        div_quot;
    logic                                    res_big;
    logic                                    ratio_big;
    logic [ldrlux_pkg::RATIO_W:0]            ratio_wide;
    logic [ldrlux_pkg::RES_W-1:0]            dist_prev;
    logic [ldrlux_pkg::RES_W-1:0]            dist_cur;
    logic                                    take_prev;
    logic                                    last_cmp;
    logic                                    out_load;
    logic [ldrlux_pkg::IDX_W-1:0]            addr_inc;

    function automatic logic [ldrlux_pkg::RES_W-1:0] abs_diff_f(
        input logic [ldrlux_pkg::RES_W-1:0]  a,
        input logic [ldrlux_pkg::TRES_W-1:0] b
    );
        logic [ldrlux_pkg::RES_W-1:0] b_ext;
        b_ext = {{(ldrlux_pkg::RES_W - ldrlux_pkg::TRES_W){1'b0}}, b};
        return (a >= b_ext) ? (a - b_ext) : (b_ext - a);
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == ldrlux_pkg::REG_SERIES) ? {12'd0, ser_reg}
                                                         : {20'd0, ref_reg};

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid & s_ready;
    assign sample_ge = (s_sample_mv >= ref_reg);
    assign ref_diff  = ref_reg - s_sample_mv;
    assign volt_prod = 32'(ser_reg) * 32'(s_sample_mv);

    // In idle the divider is loaded for the resistance when the sample is below the reference, later for the ratio.
    assign div_start = (accept & ~sample_ge) | (state_reg == S_START2);
    assign div_num   = (state_reg == S_IDLE) ? {8'd0, volt_prod} : {2'b00, r_reg, 14'd0};
    assign div_den   = (state_reg == S_IDLE) ? {5'd0, ref_diff} : sel_res_reg;

    ldrlux_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign res_big    = (div_quot[ldrlux_pkg::DIV_NUM_W-1:ldrlux_pkg::RES_W] != '0);
    assign ratio_big  = (div_quot > ldrlux_pkg::QUOT_LIMIT);
    assign ratio_wide = 19'd32768 - div_quot[ldrlux_pkg::RATIO_W:0];

    assign dist_prev = abs_diff_f(r_reg, prev_res_reg);
    assign dist_cur  = abs_diff_f(r_reg, rom_res_reg);
    assign take_prev = (dist_prev <= dist_cur);
    assign last_cmp  = (prev_idx_reg == LAST_CMP_IDX);
    assign addr_inc  = (addr_reg == LAST_IDX) ? addr_reg : addr_reg + 1'b1;
    assign out_load  = (state_reg == S_OUT) & (~m_valid_reg | m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = sample_ge ? S_ROM0 : S_DIV1;
                end
            end
            S_DIV1: begin
                if (div_stat.done) begin
                    state_next = S_ROM0;
                end
            end
            S_ROM0:   state_next = S_ROM1;
            S_ROM1:   state_next = S_SCAN;
            S_SCAN: begin
                if (take_prev || last_cmp) begin
                    state_next = S_START2;
                end
            end
            S_START2: state_next = S_DIV2;
            S_DIV2: begin
                if (div_stat.done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ref_reg     <= ldrlux_pkg::REF_RESET;
            ser_reg     <= ldrlux_pkg::SER_RESET;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                if (paddr[2] == ldrlux_pkg::REG_SERIES) begin
                    ser_reg <= pwdata[ldrlux_pkg::SER_W-1:0];
                end else begin
                    ref_reg <= pwdata[ldrlux_pkg::REF_W-1:0];
                end
            end
            case (state_reg)
                S_ROM0, S_ROM1, S_SCAN: addr_reg <= addr_inc;
                default:                addr_reg <= '0;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Table ROM with registered read data.
    always_ff @(posedge aclk) begin
        rom_res_reg <= ldrlux_pkg::tab_res_f(addr_reg);
        rom_lux_reg <= ldrlux_pkg::tab_lux_f(addr_reg);
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sat_reg <= sample_ge;
                    r_reg   <= ldrlux_pkg::RES_MAX;
                end
            end
            S_DIV1: begin
                if (div_stat.done) begin
                    sat_reg <= res_big;
                    r_reg   <= res_big ? ldrlux_pkg::RES_MAX
                                       : div_quot[ldrlux_pkg::RES_W-1:0];
                end
            end
            S_ROM1: begin
                prev_res_reg <= rom_res_reg;
                prev_lux_reg <= rom_lux_reg;
                prev_idx_reg <= '0;
            end
            S_SCAN: begin
                if (take_prev) begin
                    sel_res_reg <= prev_res_reg;
                    sel_lux_reg <= prev_lux_reg;
                    sel_idx_reg <= prev_idx_reg;
                end else if (last_cmp) begin
                    sel_res_reg <= rom_res_reg;
                    sel_lux_reg <= rom_lux_reg;
                    sel_idx_reg <= prev_idx_reg + 1'b1;
                end else begin
                    prev_res_reg <= rom_res_reg;
                    prev_lux_reg <= rom_lux_reg;
                    prev_idx_reg <= prev_idx_reg + 1'b1;
                end
            end
            S_DIV2: begin
                if (div_stat.done) begin
                    ratio_reg  <= ratio_big ? ldrlux_pkg::RATIO_MIN
                                            : ratio_wide[ldrlux_pkg::RATIO_W-1:0];
                    lux100_reg <= ldrlux_pkg::LUX100_W'(sel_lux_reg)
                                  * ldrlux_pkg::LUX100_W'(7'd100);
                    if (ratio_big) begin
                        sat_reg <= 1'b1;
                    end
                end
            end
            S_MUL: begin
                prod_reg <= 39'($signed({1'b0, lux100_reg})) * 39'($signed(ratio_reg));
            end
            default: begin
            end
        endcase
    end

    // Output register; the arithmetic shift by 14 gives the floor of the product.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_res_reg   <= r_reg;
            m_idx_reg   <= sel_idx_reg;
            m_lux_reg   <= sel_lux_reg;
            m_ratio_reg <= ratio_reg;
            m_luxm_reg  <= prod_reg[37:14];
            m_sat_reg   <= sat_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_resistance_ohms = m_res_reg;
    assign m_entry_index     = m_idx_reg;
    assign m_table_lux_deci  = m_lux_reg;
    assign m_ratio_q14       = $signed(m_ratio_reg);
    assign m_lux_milli       = $signed(m_luxm_reg);
    assign m_saturated       = m_sat_reg;

    // The ROM is never addressed beyond the last table entry during the scan.
    a_addr_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (addr_reg <= LAST_IDX))
        else $error("table address past last entry");

    // A new request is only taken when the divider is free.
    a_div_free_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !div_stat.busy)
        else $error("divider busy while idle");

    // Completion of a division is only seen in a state that waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> ((state_reg == S_DIV1) || (state_reg == S_DIV2)))
        else $error("unexpected divider completion");

    // The reported lux must belong to the reported table index.
    a_index_lux_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_idx_reg <= LAST_IDX) &&
                         (m_lux_reg == ldrlux_pkg::tab_lux_f(m_idx_reg))))
        else $error("entry index and table lux disagree");

endmodule
